@@ hw/rtl/sdss_pkg.sv @@
// shared types, constants and functions of the six-digit seven-segment scan unit
// no dependencies
`timescale 1ns / 1ps

package sdss_pkg;

	localparam int NUM_DIGITS = 6;
	localparam int DIG_IDX_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam int DIGIT_W    = 4;
	localparam int VALUE_W    = 32;
	localparam int SEG_W      = 8;
	localparam int EN_W       = 6;

	// value / 10 == (value * RECIP) >> RECIP_SHIFT for every 32-bit value
	localparam logic [VALUE_W-1:0] RECIP       = 32'hCCCC_CCCD;
	localparam int                 RECIP_SHIFT = 35;
	localparam int                 QUOT_W      = 2 * VALUE_W - RECIP_SHIFT;

	localparam logic [DIG_IDX_W-1:0] LAST_IDX = DIG_IDX_W'(NUM_DIGITS - 1);

	localparam logic [SEG_W-1:0] SEG_OFF = '0;
	localparam logic [EN_W-1:0]  EN_OFF  = '0;

	typedef logic [DIGIT_W-1:0] digit_t;

	// one count, split into decimal places, ones place at index 0
	typedef struct packed {
		logic                         blank;
		logic [NUM_DIGITS-1:0][DIGIT_W-1:0] dig;
	} sdss_rec_t;

	function automatic logic [SEG_W-1:0] seg_pattern(input digit_t d);
		logic [SEG_W-1:0] p;
		unique case (d)
			4'd0:    p = 8'h3F;
			4'd1:    p = 8'h06;
			4'd2:    p = 8'h5B;
			4'd3:    p = 8'h4F;
			4'd4:    p = 8'h66;
			4'd5:    p = 8'h6D;
			4'd6:    p = 8'h7D;
			4'd7:    p = 8'h07;
			4'd8:    p = 8'h7F;
			4'd9:    p = 8'h6F;
			default: p = SEG_OFF;
		endcase
		return p;
	endfunction

	// ones place drives the highest enable bit; bits past the field drop out
	function automatic logic [EN_W-1:0] digit_en(input logic [DIG_IDX_W-1:0] k);
		logic [EN_W-1:0] en;
		for (int b = 0; b < EN_W; b++) begin
			en[b] = (b == (NUM_DIGITS - 1 - int'(k)));
		end
		return en;
	endfunction

endpackage

@@ hw/rtl/sdss_in_if.sv @@
// input channel of the scan unit: count and blank flag with valid/ready
// depends on sdss_pkg
`timescale 1ns / 1ps

interface sdss_in_if;
	import sdss_pkg::*;

	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] count_value;
	logic               blank_all;

	modport source (output valid, output count_value, output blank_all, input ready);
	modport sink   (input valid, input count_value, input blank_all, output ready);
endinterface

@@ hw/rtl/sdss_out_if.sv @@
// result channel of the scan unit: one scan step per word with valid/ready
// depends on sdss_pkg
`timescale 1ns / 1ps

interface sdss_out_if;
	import sdss_pkg::*;

	logic             valid;
	logic             ready;
	logic [SEG_W-1:0] segments;
	logic [EN_W-1:0]  digit_enable;
	logic             last_digit;

	modport source (output valid, output segments, output digit_enable, output last_digit,
		input ready);
	modport sink   (input valid, input segments, input digit_enable, input last_digit,
		output ready);
endinterface

@@ hw/rtl/sdss_front.sv @@
// front end: accepts a count word and splits it into decimal digits, one per cycle
// depends on sdss_pkg, sdss_in_if
`timescale 1ns / 1ps

module sdss_front (
	input  logic                clk,
	input  logic                arst_n,
	sdss_in_if.sink             count,
	output logic                push_valid,
	input  logic                push_ready,
	output sdss_pkg::sdss_rec_t push_rec
);
	import sdss_pkg::*;

	logic                       busy_q;
	logic                       blank_q;
	logic [DIG_IDX_W-1:0]       cnt_q;
	logic [VALUE_W-1:0]         val_q;
	digit_t [NUM_DIGITS-1:0]    dig_q;

	logic [2*VALUE_W-1:0]       prod;
	logic [QUOT_W-1:0]          quot;
	logic [VALUE_W-1:0]         rem_full;
	digit_t                     cur_digit;
	logic                       done;
	logic                       accept;

	// divide by ten through the reciprocal, remainder by shift-add back
	assign prod      = (2*VALUE_W)'(val_q) * (2*VALUE_W)'(RECIP);
	assign quot      = prod[2*VALUE_W-1:RECIP_SHIFT];
	assign rem_full  = val_q - VALUE_W'({quot, 3'b000}) - VALUE_W'({quot, 1'b0});
	assign cur_digit = rem_full[DIGIT_W-1:0];

	assign done       = blank_q || (cnt_q == LAST_IDX);
	assign push_valid = busy_q && done;
	assign count.ready = !busy_q || (done && push_ready);
	assign accept     = count.valid && count.ready;

	// top place comes straight from the divider on the pushing cycle
	always_comb begin
		push_rec.blank = blank_q;
		for (int k = 0; k < NUM_DIGITS - 1; k++) begin
			push_rec.dig[k] = dig_q[k];
		end
		push_rec.dig[NUM_DIGITS-1] = cur_digit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q && done) begin
			if (push_ready) begin
				busy_q <= 1'b0;
			end
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			blank_q <= count.blank_all;
			val_q   <= count.count_value;
		end else if (busy_q && !done) begin
			dig_q[cnt_q] <= cur_digit;
			val_q        <= VALUE_W'(quot);
		end
	end

endmodule

@@ hw/rtl/sdss_queue.sv @@
// two-entry queue of digit records between front and back
// depends on sdss_pkg
`timescale 1ns / 1ps

module sdss_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  sdss_pkg::sdss_rec_t push_rec,
	output logic                head_valid,
	input  logic                pop,
	output sdss_pkg::sdss_rec_t head_rec
);
	import sdss_pkg::*;

	sdss_rec_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign head_valid = (fill_q != 2'd0);
	assign head_rec   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

endmodule

@@ hw/rtl/sdss_back.sv @@
// back end: walks a digit record, one scan word per digit (one only if blank)
// depends on sdss_pkg, sdss_out_if
`timescale 1ns / 1ps

module sdss_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  sdss_pkg::sdss_rec_t head_rec,
	output logic                pop,
	sdss_out_if.source          scan
);
	import sdss_pkg::*;

	logic [DIG_IDX_W-1:0]  idx_q;
	logic                  ov_q;
	logic [SEG_W-1:0]      seg_q;
	logic [EN_W-1:0]       en_q;
	logic                  last_q;

	logic [NUM_DIGITS-1:0] nz_above;
	logic                  shown;
	logic                  out_adv;
	logic                  emit;
	logic                  last;

	// place is lit when it or any higher place is nonzero; the ones place is always lit
	always_comb begin
		nz_above[NUM_DIGITS-1] = (head_rec.dig[NUM_DIGITS-1] != '0);
		for (int k = NUM_DIGITS - 2; k >= 0; k--) begin
			nz_above[k] = nz_above[k+1] || (head_rec.dig[k] != '0);
		end
	end

	assign shown   = (idx_q == '0) || nz_above[idx_q];
	assign out_adv = !ov_q || scan.ready;
	assign emit    = head_valid && out_adv;
	assign last    = head_rec.blank || (idx_q == LAST_IDX);
	assign pop     = emit && last;

	assign scan.valid        = ov_q;
	assign scan.segments     = seg_q;
	assign scan.digit_enable = en_q;
	assign scan.last_digit   = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			idx_q <= '0;
		end else if (emit) begin
			ov_q  <= 1'b1;
			idx_q <= last ? '0 : idx_q + 1'b1;
		end else if (scan.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			last_q <= last;
			if (head_rec.blank) begin
				seg_q <= SEG_OFF;
				en_q  <= EN_OFF;
			end else begin
				seg_q <= seg_pattern(head_rec.dig[idx_q]);
				en_q  <= shown ? digit_en(idx_q) : EN_OFF;
			end
		end
	end

endmodule

@@ hw/rtl/six_digit_seven_segment_scan_unit.sv @@
// Six-digit seven-segment scan unit. Each count word on the count channel becomes six scan
// words on the scan channel, ones place first (enable 0x20) up to hundred-thousands (0x01),
// each with a common-cathode segment byte; leading zeros above the ones place keep the zero
// pattern but get enable 0, and last_digit marks the sixth word. A word with blank_all set
// gives a single all-off word with last_digit high. The front end peels one decimal digit per
// cycle with a 32x32 reciprocal multiply, holding a finished record while the queue is full,
// and the back end sends one scan word per cycle while the scan channel is ready. A two-entry
// record queue lets the front split the next count while the back is still scanning. Each
// record is registered in the queue and each scan word in the back end. No configuration.
// depends on sdss_pkg, sdss_in_if, sdss_out_if, sdss_front, sdss_queue, sdss_back
`timescale 1ns / 1ps

module six_digit_seven_segment_scan_unit (
	input  logic       clk,
	input  logic       arst_n,
	sdss_in_if.sink    count,
	sdss_out_if.source scan
);
	import sdss_pkg::*;

	logic      push_valid;
	logic      push_ready;
	sdss_rec_t push_rec;
	logic      head_valid;
	logic      pop;
	sdss_rec_t head_rec;

	sdss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.count      (count),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_rec   (push_rec)
	);

	sdss_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_rec   (push_rec),
		.head_valid (head_valid),
		.pop        (pop),
		.head_rec   (head_rec)
	);

	sdss_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_rec   (head_rec),
		.pop        (pop),
		.scan       (scan)
	);

endmodule

@@ tb/sv/tb_six_digit_seven_segment_scan_unit.sv @@
// self-checking bench for the six-digit seven-segment scan unit: random and directed counts
// in, each scan word checked against a digit-splitting predictor; depends on sdss_pkg,
// sdss_in_if, sdss_out_if and six_digit_seven_segment_scan_unit
`timescale 1ns / 1ps

module tb_six_digit_seven_segment_scan_unit;
	import sdss_pkg::*;

	localparam int RANDOM_COUNTS = 190;
	localparam int STALL_LIMIT   = 1000;
	localparam int DRAIN_CYCLES  = 24;
	localparam int HOLD_AFTER    = 150;
	localparam int HOLD_CYCLES   = 90;

	// common-cathode patterns, digit 9 first so that index d gives digit d
	localparam logic [9:0][SEG_W-1:0] SEG_OF_DIGIT = {
		8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
	};

	typedef struct packed {
		logic [VALUE_W-1:0] count_value;
		logic               blank_all;
	} count_word_t;

	typedef struct packed {
		logic [SEG_W-1:0] segments;
		logic [EN_W-1:0]  digit_enable;
		logic             last_digit;
	} scan_word_t;

	typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_LIGHT} rx_style_t;

	logic clk;
	logic arst_n;

	sdss_in_if  count_if ();
	sdss_out_if scan_if ();

	six_digit_seven_segment_scan_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.count  (count_if),
		.scan   (scan_if)
	);

	count_word_t count_words_pending[$];
	scan_word_t  scan_words_due[$];

	int  count_total;
	int  count_taken;
	int  scan_taken;
	int  mismatches;
	int  idle_cycles;
	bit  count_fired;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic note_miss(input string detail);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch: %s", detail);
		end
	endtask

	// splits the count into places, ones first, and queues the scan words it should give
	function automatic void predict_scan_words(input count_word_t w);
		logic [VALUE_W-1:0] rest;
		logic [3:0]         place_digit [NUM_DIGITS];
		bit                 shown [NUM_DIGITS];
		bit                 above;
		int                 pos;
		scan_word_t         sw;
		if (w.blank_all) begin
			sw.segments     = '0;
			sw.digit_enable = '0;
			sw.last_digit   = 1'b1;
			scan_words_due.push_back(sw);
			return;
		end
		rest = w.count_value;
		for (int k = 0; k < NUM_DIGITS; k++) begin
			place_digit[k] = 4'(rest % 10);
			rest = rest / 10;
		end
		// leading zeros stay dark, the ones place always lights
		above = 1'b0;
		for (int k = NUM_DIGITS - 1; k >= 0; k--) begin
			if (place_digit[k] != 4'd0) above = 1'b1;
			shown[k] = above || (k == 0);
		end
		for (int k = 0; k < NUM_DIGITS; k++) begin
			pos = NUM_DIGITS - 1 - k;
			sw.segments     = SEG_OF_DIGIT[place_digit[k]];
			sw.digit_enable = '0;
			if (shown[k] && pos < EN_W) sw.digit_enable[pos] = 1'b1;
			sw.last_digit   = (k == NUM_DIGITS - 1);
			scan_words_due.push_back(sw);
		end
	endfunction

	task automatic queue_count(input logic [VALUE_W-1:0] value, input logic blank);
		count_word_t w;
		w.count_value = value;
		w.blank_all   = blank;
		count_words_pending.push_back(w);
	endtask

	// counts weighted toward few digits, round numbers and wrap past a million
	function automatic logic [VALUE_W-1:0] random_count();
		int unsigned scale;
		int unsigned value;
		scale = 1;
		repeat ($urandom_range(1, 6)) scale = scale * 10;
		case ($urandom_range(0, 5))
			0: value = $urandom_range(0, 9);
			1: value = $urandom_range(0, scale - 1);
			2: value = $urandom_range(1, 9) * (scale / 10);
			3: value = 1000000 * $urandom_range(0, 4294) + $urandom_range(0, 999999);
			default: value = $urandom;
		endcase
		return value;
	endfunction

	// count side acceptance, scan side check and the idle counter
	always @(posedge clk) begin
		count_word_t taken;
		scan_word_t  got;
		scan_word_t  want;
		count_fired = count_if.valid && count_if.ready;
		if (count_fired) begin
			taken.count_value = count_if.count_value;
			taken.blank_all   = count_if.blank_all;
			predict_scan_words(taken);
			count_taken++;
		end
		if (scan_if.valid && scan_if.ready) begin
			got.segments     = scan_if.segments;
			got.digit_enable = scan_if.digit_enable;
			got.last_digit   = scan_if.last_digit;
			scan_taken++;
			if (scan_words_due.size() == 0) begin
				note_miss($sformatf("word %0d not expected: seg %h en %h last %b",
					scan_taken, got.segments, got.digit_enable, got.last_digit));
			end else begin
				want = scan_words_due.pop_front();
				if (got.segments !== want.segments)
					note_miss($sformatf("word %0d segments exp %h got %h",
						scan_taken, want.segments, got.segments));
				if (got.digit_enable !== want.digit_enable)
					note_miss($sformatf("word %0d digit_enable exp %h got %h",
						scan_taken, want.digit_enable, got.digit_enable));
				if (got.last_digit !== want.last_digit)
					note_miss($sformatf("word %0d last_digit exp %b got %b",
						scan_taken, want.last_digit, got.last_digit));
			end
			idle_cycles = 0;
		end else if (count_fired || !arst_n) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
	end

	// count driver: bursts of back-to-back words with random gaps between them
	int burst_left;
	int gap_left;

	always @(negedge clk) begin
		logic        next_valid;
		count_word_t w;
		if (arst_n) begin
			next_valid = count_if.valid;
			if (count_if.valid && count_fired) next_valid = 1'b0;
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (count_words_pending.size() > 0) begin
					w = count_words_pending.pop_front();
					count_if.count_value <= w.count_value;
					count_if.blank_all   <= w.blank_all;
					next_valid = 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 13);
					end else begin
						burst_left--;
					end
				end
			end
			count_if.valid <= next_valid;
		end
	end

	// scan receiver: changing stall styles plus one long hold-off to back up the unit
	rx_style_t rx_style;
	int        style_left;
	int        hold_left;
	bit        hold_done;
	int        rx_tick;

	always @(negedge clk) begin
		logic rdy;
		if (arst_n) begin
			if (!hold_done && scan_taken >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				if (style_left == 0) begin
					rx_style   = rx_style_t'($urandom_range(0, 3));
					style_left = $urandom_range(16, 64);
				end
				style_left--;
				rx_tick++;
				case (rx_style)
					RX_FREE:   rdy = 1'b1;
					RX_COIN:   rdy = ($urandom_range(0, 1) == 1);
					RX_SPARSE: rdy = (rx_tick % 4) == 0;
					default:   rdy = $urandom_range(0, 7) != 0;
				endcase
			end
			scan_if.ready <= rdy;
		end
	end

	initial begin : watchdog
		wait (idle_cycles >= STALL_LIMIT);
		$display("stalled for %0d cycles", STALL_LIMIT);
		$display("FAIL");
		$finish;
	end

	initial begin
		scan_word_t left;
		arst_n               = 1'b0;
		count_if.valid       = 1'b0;
		count_if.count_value = '0;
		count_if.blank_all   = 1'b0;
		scan_if.ready        = 1'b0;

		// directed: all zeros, wrap, digit eight, inner zeros, full width, blanking
		queue_count(32'd0, 1'b0);
		queue_count(32'd7, 1'b0);
		queue_count(32'd10, 1'b0);
		queue_count(32'd1000, 1'b0);
		queue_count(32'd100001, 1'b0);
		queue_count(32'd100000, 1'b0);
		queue_count(32'd500000, 1'b0);
		queue_count(32'd999999, 1'b0);
		queue_count(32'd1000000, 1'b0);
		queue_count(32'd1000001, 1'b0);
		queue_count(32'd123456, 1'b0);
		queue_count(32'd876543, 1'b0);
		queue_count(32'd88888888, 1'b0);
		queue_count(32'd90817, 1'b0);
		queue_count(32'hFFFF_FFFF, 1'b0);
		queue_count(32'h8000_0000, 1'b0);
		queue_count(32'h5555_5555, 1'b0);
		queue_count(32'd0, 1'b1);
		queue_count(32'hFFFF_FFFF, 1'b1);
		queue_count(32'd123, 1'b1);
		queue_count(32'd8, 1'b0);
		for (int i = 0; i < RANDOM_COUNTS; i++) begin
			queue_count(random_count(), $urandom_range(0, 6) == 0);
		end
		count_total = count_words_pending.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (count_taken < count_total) @(posedge clk);
		while (scan_words_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		while (scan_words_due.size() != 0) begin
			left = scan_words_due.pop_front();
			note_miss($sformatf("missing word: seg %h en %h last %b",
				left.segments, left.digit_enable, left.last_digit));
		end
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
